### design/sm3c_pkg.sv
`default_nettype none

package sm3c_pkg;

   localparam int WORD_W     = 32;
   localparam int IV_WORDS   = 8;
   localparam int BLK_WORDS  = 16;
   localparam int ROUNDS     = 64;
   localparam int CSR_IDX_W  = 4;
   localparam int ROUND_W    = $clog2(ROUNDS);
   localparam int WCNT_W     = $clog2(BLK_WORDS);
   localparam int OIDX_W     = $clog2(IV_WORDS);

   localparam logic [WORD_W-1:0] T_LOW  = 32'h79CC4519;
   localparam logic [WORD_W-1:0] T_HIGH = 32'h7A879D8A;

   localparam logic [WORD_W-1:0] IV_RESET [IV_WORDS] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   // The second constant enters at round 16, already rotated by sixteen.
   localparam logic [WORD_W-1:0] T_HIGH_ROT16 = {T_HIGH[15:0], T_HIGH[31:16]};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_OUTPUT
   } sm3c_state_type;

   typedef struct packed {
      logic               shift_word;
      logic               load_iv;
      logic               start_rounds;
      logic               round_en;
      logic [ROUND_W-1:0] round_idx;
      logic               fold;
      logic [OIDX_W-1:0]  out_idx;
   } sm3c_cmd_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                              input logic [4:0] n);
      rotl = (v << n) | (v >> (6'd32 - {1'b0, n}));
   endfunction

   function automatic logic [WORD_W-1:0] perm0(input logic [WORD_W-1:0] v);
      perm0 = v ^ rotl(v, 5'd9) ^ rotl(v, 5'd17);
   endfunction

   function automatic logic [WORD_W-1:0] perm1(input logic [WORD_W-1:0] v);
      perm1 = v ^ rotl(v, 5'd15) ^ rotl(v, 5'd23);
   endfunction

endpackage

`default_nettype wire

### design/sm3c_ctrl.sv
`default_nettype none

module sm3c_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  req_new_message,
   input  wire logic                  req_final_block,
   output logic                       busy,
   output logic                       rsp_valid,
   output logic [sm3c_pkg::OIDX_W-1:0] rsp_digest_index,
   output logic                       rsp_digest_last,
   output sm3c_pkg::sm3c_cmd_type     cmd
);
   import sm3c_pkg::*;

   sm3c_state_type      state_ff, state_in;
   logic [WCNT_W-1:0]   word_cnt_ff, word_cnt_in;
   logic [ROUND_W-1:0]  round_cnt_ff, round_cnt_in;
   logic [OIDX_W-1:0]   out_cnt_ff, out_cnt_in;
   logic                final_ff, final_in;
   logic                accept;
   logic                last_word;

   assign accept    = start && (state_ff == ST_IDLE);
   assign last_word = (word_cnt_ff == WCNT_W'(BLK_WORDS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && last_word) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (round_cnt_ff == ROUND_W'(ROUNDS - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            state_in = final_ff ? ST_OUTPUT : ST_IDLE;
         end
         ST_OUTPUT: begin
            if (out_cnt_ff == OIDX_W'(IV_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      word_cnt_in  = accept ? word_cnt_ff + WCNT_W'(1) : word_cnt_ff;
      round_cnt_in = (state_ff == ST_ROUND) ? round_cnt_ff + ROUND_W'(1) : '0;
      out_cnt_in   = (state_ff == ST_OUTPUT) ? out_cnt_ff + OIDX_W'(1) : '0;
      final_in     = (accept && last_word) ? req_final_block : final_ff;
   end

   always_comb begin
      busy             = (state_ff != ST_IDLE);
      rsp_valid        = (state_ff == ST_OUTPUT);
      rsp_digest_index = out_cnt_ff;
      rsp_digest_last  = (out_cnt_ff == OIDX_W'(IV_WORDS - 1));
      cmd.shift_word   = accept;
      cmd.load_iv      = accept && (word_cnt_ff == '0) && req_new_message;
      cmd.start_rounds = accept && last_word;
      cmd.round_en     = (state_ff == ST_ROUND);
      cmd.round_idx    = round_cnt_ff;
      cmd.fold         = (state_ff == ST_FOLD);
      cmd.out_idx      = out_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         word_cnt_ff  <= '0;
         round_cnt_ff <= '0;
         out_cnt_ff   <= '0;
         final_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_cnt_ff  <= word_cnt_in;
         round_cnt_ff <= round_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         final_ff     <= final_in;
      end
   end

endmodule

`default_nettype wire

### design/sm3c_datapath.sv
`default_nettype none

module sm3c_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire sm3c_pkg::sm3c_cmd_type         cmd,
   input  wire logic [sm3c_pkg::WORD_W-1:0]    req_msg_word,
   input  wire logic                           csr_write_en,
   input  wire logic [sm3c_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sm3c_pkg::WORD_W-1:0]    csr_wdata,
   output logic [sm3c_pkg::WORD_W-1:0]         rsp_digest_word
);
   import sm3c_pkg::*;

   logic [WORD_W-1:0] iv_ff     [IV_WORDS];
   logic [WORD_W-1:0] chain_ff  [IV_WORDS];
   logic [WORD_W-1:0] work_ff   [IV_WORDS];
   logic [WORD_W-1:0] work_in   [IV_WORDS];
   logic [WORD_W-1:0] block_buffer_ff [BLK_WORDS];
   logic [WORD_W-1:0] tj_ff, tj_in;

   logic [WORD_W-1:0] expand_word;
   logic [WORD_W-1:0] shift_in_word;
   logic [WORD_W-1:0] a12, ss1, ss2, ffj, ggj, tt1, tt2, wj, wpj;
   logic              low_rounds;

   // The message window holds W[j] .. W[j+15]; each round appends W[j+16].
   assign expand_word = perm1(block_buffer_ff[0] ^ block_buffer_ff[7]
                              ^ rotl(block_buffer_ff[13], 5'd15))
                        ^ rotl(block_buffer_ff[3], 5'd7) ^ block_buffer_ff[10];
   assign shift_in_word = cmd.round_en ? expand_word : req_msg_word;

   assign low_rounds = (cmd.round_idx < ROUND_W'(16));
   assign wj  = block_buffer_ff[0];
   assign wpj = block_buffer_ff[0] ^ block_buffer_ff[4];

   always_comb begin
      a12 = rotl(work_ff[0], 5'd12);
      ss1 = rotl(a12 + work_ff[4] + tj_ff, 5'd7);
      ss2 = ss1 ^ a12;
      if (low_rounds) begin
         ffj = work_ff[0] ^ work_ff[1] ^ work_ff[2];
         ggj = work_ff[4] ^ work_ff[5] ^ work_ff[6];
      end else begin
         ffj = (work_ff[0] & work_ff[1]) | (work_ff[0] & work_ff[2])
               | (work_ff[1] & work_ff[2]);
         ggj = (work_ff[4] & work_ff[5]) | (~work_ff[4] & work_ff[6]);
      end
      tt1 = ffj + work_ff[3] + ss2 + wpj;
      tt2 = ggj + work_ff[7] + ss1 + wj;
      work_in[0] = tt1;
      work_in[1] = work_ff[0];
      work_in[2] = rotl(work_ff[1], 5'd9);
      work_in[3] = work_ff[2];
      work_in[4] = perm0(tt2);
      work_in[5] = work_ff[4];
      work_in[6] = rotl(work_ff[5], 5'd19);
      work_in[7] = work_ff[6];
   end

   always_comb begin
      if (cmd.round_idx == ROUND_W'(15)) begin
         tj_in = T_HIGH_ROT16;
      end else begin
         tj_in = rotl(tj_ff, 5'd1);
      end
   end

   assign rsp_digest_word = chain_ff[cmd.out_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < IV_WORDS; i++) begin
            iv_ff[i]    <= IV_RESET[i];
            chain_ff[i] <= IV_RESET[i];
         end
      end else begin
         if (csr_write_en && (csr_index < CSR_IDX_W'(IV_WORDS))) begin
            iv_ff[csr_index[OIDX_W-1:0]] <= csr_wdata;
         end
         if (cmd.load_iv) begin
            for (int i = 0; i < IV_WORDS; i++) begin
               chain_ff[i] <= iv_ff[i];
            end
         end else if (cmd.fold) begin
            for (int i = 0; i < IV_WORDS; i++) begin
               chain_ff[i] <= chain_ff[i] ^ work_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift_word || cmd.round_en) begin
         for (int i = 0; i < BLK_WORDS - 1; i++) begin
            block_buffer_ff[i] <= block_buffer_ff[i + 1];
         end
         block_buffer_ff[BLK_WORDS - 1] <= shift_in_word;
      end
      if (cmd.start_rounds) begin
         tj_ff <= T_LOW;
         for (int i = 0; i < IV_WORDS; i++) begin
            work_ff[i] <= chain_ff[i];
         end
      end else if (cmd.round_en) begin
         tj_ff <= tj_in;
         for (int i = 0; i < IV_WORDS; i++) begin
            work_ff[i] <= work_in[i];
         end
      end
   end

endmodule

`default_nettype wire

### design/sm3_hash_compression.sv
// Channel    Ports                                               Handshake
// request    req_msg_word, req_new_message, req_final_block     start high, busy low
// response   rsp_digest_word, rsp_digest_index, rsp_digest_last rsp_valid, one cycle
// csr        csr_index, csr_wdata                                csr_write_en
//
// Words 0 to 14 of a block are taken one per cycle with busy staying low.
// The sixteenth word starts the 64 rounds of the single round unit and the fold
// step; a final block then adds its 8 digest words on consecutive cycles.
// Reset is synchronous and loads the standard IV into the IV registers and
// the chaining value. Results cannot be stalled by the receiver.
`default_nettype none

module sm3_hash_compression (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [sm3c_pkg::WORD_W-1:0]    req_msg_word,
   input  wire logic                           req_new_message,
   input  wire logic                           req_final_block,
   output logic                                rsp_valid,
   output logic [sm3c_pkg::WORD_W-1:0]         rsp_digest_word,
   output logic [sm3c_pkg::OIDX_W-1:0]         rsp_digest_index,
   output logic                                rsp_digest_last,
   input  wire logic                           csr_write_en,
   input  wire logic [sm3c_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sm3c_pkg::WORD_W-1:0]    csr_wdata
);
   import sm3c_pkg::*;

   sm3c_cmd_type cmd;

   sm3c_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_new_message  (req_new_message),
      .req_final_block  (req_final_block),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last),
      .cmd              (cmd)
   );

   sm3c_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_msg_word    (req_msg_word),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_digest_word (rsp_digest_word)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("Digest word presented while the block is idle.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_digest_last) |=> !rsp_valid)
      else $error("Digest transaction continued past its last word.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_digest_last) |=>
         (rsp_valid && (rsp_digest_index == $past(rsp_digest_index) + OIDX_W'(1))))
      else $error("Digest words are not consecutive.");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.round_en && !$past(cmd.round_en)) |-> (cmd.round_idx == '0))
      else $error("Round sequence did not start at round zero.");

endmodule

`default_nettype wire
